/* sv/dspf_pkg.sv */
// ----------------------------------------------------------------------------
// dspf_pkg
// Shared types and constants of the dirty-page flush block: item and result
// payloads, command codes, panel addressing bytes and the sequencer states.
// ----------------------------------------------------------------------------
package dspf_pkg;

	// One input item
	typedef struct packed {
		logic [2:0] command;
		logic [2:0] page;
		logic [6:0] column;
		logic [7:0] value;
	} dspf_item_t;

	// One result item
	typedef struct packed {
		logic        kind;
		logic [63:0] payload;
		logic [3:0]  byte_count;
		logic [2:0]  sent_page;
		logic        last;
	} dspf_result_t;

	// Command codes
	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_OR    = 3'd1;
	localparam logic [2:0] CMD_CLEAR = 3'd2;
	localparam logic [2:0] CMD_FLUSH = 3'd3;
	localparam logic [2:0] CMD_INVAL = 3'd4;

	// Result kinds
	localparam logic KIND_ADDR = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// Panel addressing bytes and shadow fill value
	localparam logic [7:0] PAGE_ADDR_BASE = 8'hB0;
	localparam logic [7:0] COL_LOW_CMD    = 8'h00;
	localparam logic [7:0] COL_HIGH_CMD   = 8'h10;
	localparam logic [7:0] SHADOW_FILL    = 8'hFF;
	localparam logic [3:0] ADDR_CMD_BYTES = 4'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_SWEEP,
		ST_SCAN,
		ST_CMD,
		ST_EMIT
	} dspf_state_t;

	// Sequencer to chunk packer
	typedef struct packed {
		logic       load_cmd;
		logic [3:0] cmd_page;
		logic       cap;
		logic [2:0] lane;
		logic [7:0] data;
		logic       close;
		logic       last;
	} dspf_pack_t;

	// Chunk packer status back to the sequencer
	typedef struct packed {
		logic out_free;
		logic moved;
		logic moved_last;
	} dspf_pack_stat_t;

endpackage

/* sv/dspf_ram.sv */
// ----------------------------------------------------------------------------
// dspf_ram
// Byte-wide simple dual-port RAM, one write and one read port, registered
// read data. Read during write returns the old byte.
// ----------------------------------------------------------------------------
module dspf_ram #(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [0:(1<<AW)-1];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

/* sv/dspf_pack.sv */
// ----------------------------------------------------------------------------
// dspf_pack
// Packs frame bytes into 8-byte data chunks and holds the result output
// register. Loads either an addressing result or a finished chunk.
// ----------------------------------------------------------------------------
module dspf_pack import dspf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  dspf_pack_t      ctl,
	output dspf_pack_stat_t stat,
	output logic            result_valid,
	input  logic            result_stall,
	output dspf_result_t    result
);

	logic [63:0]  chunk_q;
	logic [3:0]   count_q;
	logic         last_q;
	logic [3:0]   page_q;
	logic         rdy_q;
	logic         out_valid_q;
	dspf_result_t out_q;

	logic out_free;
	logic moved;

	assign out_free = !out_valid_q || !result_stall;
	assign moved    = rdy_q && out_free;

	assign stat.out_free   = out_free;
	assign stat.moved      = moved;
	assign stat.moved_last = moved && last_q;

	// chunk assembly; lanes not written stay zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			count_q <= '0;
			last_q  <= 1'b0;
			page_q  <= '0;
			rdy_q   <= 1'b0;
		end else begin
			if (moved) begin
				chunk_q <= '0;
				rdy_q   <= 1'b0;
			end else if (ctl.cap) begin
				chunk_q[{ctl.lane, 3'b000} +: 8] <= ctl.data;
				if (ctl.close) begin
					rdy_q   <= 1'b1;
					count_q <= {1'b0, ctl.lane} + 4'd1;
					last_q  <= ctl.last;
					page_q  <= ctl.cmd_page;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (ctl.load_cmd && out_free) begin
				out_valid_q      <= 1'b1;
				out_q.kind       <= KIND_ADDR;
				out_q.payload    <= {40'd0, COL_HIGH_CMD, COL_LOW_CMD,
					PAGE_ADDR_BASE | {4'd0, ctl.cmd_page}};
				out_q.byte_count <= ADDR_CMD_BYTES;
				out_q.sent_page  <= ctl.cmd_page[2:0];
				out_q.last       <= 1'b0;
			end else if (moved) begin
				out_valid_q      <= 1'b1;
				out_q.kind       <= KIND_DATA;
				out_q.payload    <= chunk_q;
				out_q.byte_count <= count_q;
				out_q.sent_page  <= page_q[2:0];
				out_q.last       <= last_q;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* sv/display_dirty_page_flush.sv */
// ----------------------------------------------------------------------------
// display_dirty_page_flush
// Page-organized frame store with a shadow of the panel contents and a
// dirty-page flush that emits page addressing bytes and 8-byte data chunks.
// ----------------------------------------------------------------------------
// The block holds one item at a time: item_stall is high from the cycle after
// a transfer until the item's work is done. A write or OR to a page already
// written since the last clear is a read, modify and write on the frame RAM
// (states RMW_RD, RMW_WR). The first write or OR to a page after reset or a
// clear frame zeroes that page row, placing the item's byte as it sweeps.
// Clear frame and invalidate shadow never stall the block: per-page valid
// bits mark which rows of the frame and shadow RAMs hold live data; a frame
// row not valid reads as zero and a shadow row not valid reads as 0xFF, so
// neither RAM needs a clearing pass after reset. A flush compares frame and
// shadow one byte per cycle, passing over each clean page in turn, and sends
// nothing when nothing is dirty. For the dirty page it sends the addressing
// result, then reads the page through the single frame read port, one byte
// per cycle until a chunk is read out, copying each byte into the shadow as
// it goes; each data chunk is handed to the output register before the next
// chunk's reads start. Results leave through an output register, so a
// stalled result transfer only holds the sequencer when a new result is ready.
// ----------------------------------------------------------------------------
module display_dirty_page_flush import dspf_pkg::*; #(
	parameter int PAGES = 8,
	parameter int WIDTH = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  dspf_item_t   item,
	output logic         result_valid,
	input  logic         result_stall,
	output dspf_result_t result
);

	localparam int CW = $clog2(WIDTH);
	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int AW = PW + CW;

	dspf_state_t state_q, state_d;

	// item registers
	logic [PW-1:0] pg_q;          // item page, then the page being scanned/sent
	logic [CW-1:0] tcol_q;
	logic [7:0]    val_q;
	logic          or_q;

	// sequencing
	logic [CW-1:0] cnt_q;         // column counter for sweep, scan and send
	logic          iss_q;         // reads of the current row still to issue
	logic          wait_q;        // chunk read out, waiting for handoff
	logic [PW-1:0] attempt_q;
	logic [PW-1:0] scan_start_q;
	logic [PAGES-1:0] fvalid_q;
	logic [PAGES-1:0] svalid_q;

	// read stage
	logic          vld_s1;
	logic          last_s1;
	logic [CW-1:0] col_s1;

	// RAM ports
	logic          f_we, s_we;
	logic [AW-1:0] f_waddr, f_raddr, s_waddr;
	logic [7:0]    f_wdata, f_rdata, s_rdata;

	dspf_pack_t      pctl;
	dspf_pack_stat_t pstat;

	logic          issue;
	logic          in_ok;
	logic [PW-1:0] in_pg;
	logic [CW-1:0] in_col;
	logic          col_last;
	logic          close_issue;
	logic [PW-1:0] pg_next;
	logic [7:0]    fb_s1;
	logic [7:0]    sb_s1;
	logic          differ_s1;

	assign in_ok    = (32'(item.page) < 32'(PAGES)) && (32'(item.column) < 32'(WIDTH));
	assign in_pg    = PW'(item.page);
	assign in_col   = CW'(item.column);
	assign col_last = (cnt_q == CW'(WIDTH - 1));
	assign close_issue = (cnt_q[2:0] == 3'd7) || col_last;
	assign pg_next  = (pg_q == PW'(PAGES - 1)) ? '0 : pg_q + 1'b1;

	// effective bytes: rows never written since clear or invalidate read as reset value
	assign fb_s1     = fvalid_q[pg_q] ? f_rdata : 8'h00;
	assign sb_s1     = svalid_q[pg_q] ? s_rdata : SHADOW_FILL;
	assign differ_s1 = vld_s1 && (fb_s1 != sb_s1);

	assign item_stall = (state_q != ST_IDLE);

	dspf_ram #(.AW(AW)) u_frame (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	dspf_ram #(.AW(AW)) u_shadow (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (fb_s1),
		.raddr (f_raddr),
		.rdata (s_rdata)
	);

	dspf_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (pctl),
		.stat         (pstat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM and packer controls
	always_comb begin
		state_d       = state_q;
		issue         = 1'b0;
		f_we          = 1'b0;
		f_waddr       = {pg_q, cnt_q};
		f_wdata       = val_q;
		f_raddr       = {pg_q, cnt_q};
		s_we          = 1'b0;
		s_waddr       = {pg_q, col_s1};
		pctl          = '0;
		pctl.cmd_page = 4'(pg_q);
		pctl.lane     = col_s1[2:0];
		pctl.data     = fb_s1;
		pctl.close    = (col_s1[2:0] == 3'd7) || last_s1;
		pctl.last     = last_s1;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (item.command)
						CMD_WRITE, CMD_OR: begin
							if (in_ok) begin
								state_d = fvalid_q[in_pg] ? ST_RMW_RD : ST_SWEEP;
							end
						end
						CMD_FLUSH: state_d = ST_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RMW_RD: begin
				f_raddr = {pg_q, tcol_q};
				state_d = ST_RMW_WR;
			end
			ST_RMW_WR: begin
				f_we    = 1'b1;
				f_waddr = {pg_q, tcol_q};
				f_wdata = or_q ? (f_rdata | val_q) : val_q;
				state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				// zero the row, target byte gets the value (OR into zero too)
				f_we    = 1'b1;
				f_wdata = (cnt_q == tcol_q) ? val_q : 8'h00;
				if (col_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				// stop reading as soon as a byte differs
				issue = iss_q && !differ_s1;
				if (differ_s1) begin
					state_d = ST_CMD;
				end else if (vld_s1 && last_s1 && attempt_q == PW'(PAGES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_CMD: begin
				pctl.load_cmd = 1'b1;
				if (pstat.out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				issue    = iss_q && !wait_q;
				s_we     = vld_s1;
				pctl.cap = vld_s1;
				if (pstat.moved_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// counters, valid bits and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q         <= '0;
			tcol_q       <= '0;
			val_q        <= '0;
			or_q         <= 1'b0;
			cnt_q        <= '0;
			iss_q        <= 1'b0;
			wait_q       <= 1'b0;
			attempt_q    <= '0;
			scan_start_q <= '0;
			fvalid_q     <= '0;
			svalid_q     <= '0;
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
			col_s1       <= '0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				last_s1 <= col_last;
				col_s1  <= cnt_q;
				cnt_q   <= cnt_q + 1'b1;
				if (col_last) begin
					iss_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						pg_q   <= (item.command == CMD_FLUSH) ? scan_start_q : in_pg;
						tcol_q <= in_col;
						val_q  <= item.value;
						or_q   <= (item.command == CMD_OR);
						cnt_q  <= '0;
						unique case (item.command)
							CMD_CLEAR: fvalid_q <= '0;
							CMD_INVAL: begin
								svalid_q     <= '0;
								scan_start_q <= '0;
							end
							CMD_FLUSH: begin
								attempt_q <= '0;
								iss_q     <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (col_last) begin
						fvalid_q[pg_q] <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (!differ_s1 && vld_s1 && last_s1 && attempt_q != PW'(PAGES - 1)) begin
						attempt_q <= attempt_q + 1'b1;
						pg_q      <= pg_next;
						cnt_q     <= '0;
						iss_q     <= 1'b1;
					end
				end
				ST_CMD: begin
					if (pstat.out_free) begin
						cnt_q  <= '0;
						iss_q  <= 1'b1;
						wait_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (issue && close_issue) begin
						wait_q <= 1'b1;
					end else if (pstat.moved) begin
						wait_q <= 1'b0;
					end
					if (pstat.moved_last) begin
						svalid_q[pg_q] <= 1'b1;
						scan_start_q   <= pg_next;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* sv/dspf_check.sv */
// ----------------------------------------------------------------------------
// dspf_check
// Port-level checks of the dirty-page flush block, bound to the top level.
// ----------------------------------------------------------------------------
module dspf_check import dspf_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         item_valid,
	input logic         item_stall,
	input dspf_item_t   item,
	input logic         result_valid,
	input logic         result_stall,
	input dspf_result_t result
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a flush makes the block busy after its transfer
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.command == CMD_FLUSH |=> item_stall)
		else $error("flush did not occupy the block");

	// clearing the frame does not stall the item input
	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.command == CMD_CLEAR |=> !item_stall)
		else $error("clear frame held the block");

	// addressing result shape
	a_addr_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_ADDR |->
			result.byte_count == ADDR_CMD_BYTES && !result.last &&
			result.payload[7:4] == PAGE_ADDR_BASE[7:4] &&
			result.payload[23:8] == {COL_HIGH_CMD, COL_LOW_CMD})
		else $error("malformed addressing result");

endmodule

bind display_dirty_page_flush dspf_check u_dspf_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

/* bench/display_dirty_page_flush_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_dirty_page_flush_tb
// Self-checking bench for the dirty-page flush block. A directed table covers
// reset state, extremes, clear/invalidate and the all-clean flush, then random
// write/OR/flush traffic runs against a local model of frame, shadow and scan
// pointer. Both channels idle at random, and one long result hold-off backs
// the block up into its item input.
// ----------------------------------------------------------------------------
module display_dirty_page_flush_tb;
	import dspf_pkg::*;

	localparam int NPAGES = 8;
	localparam int NCOLS  = 128;

	// Codes the block decodes as no-ops
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	localparam int RAND_ITEMS     = 155;
	localparam int SQUEEZE_AT     = 100;	// result count where the long hold-off starts
	localparam int SQUEEZE_CYCLES = 400;
	// full scan of clean pages plus one page of output: covers a trailing no-op flush
	localparam int TAIL_CYCLES    = NPAGES * (NCOLS + 1) + 256;

	// One directed step. When pinned, the addressing result of a flush is
	// written out in the table instead of taken from the model.
	typedef struct packed {
		dspf_item_t   stim;
		logic         pinned;
		dspf_result_t pin;
	} dir_row_t;

	localparam dspf_result_t NO_PIN = '0;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         item_valid;
	logic         item_stall;
	dspf_item_t   item;
	logic         result_valid;
	logic         result_stall;
	dspf_result_t result;

	// Local copy of the block's state
	logic [7:0]   frame_mem  [NPAGES][NCOLS];
	logic [7:0]   shadow_mem [NPAGES][NCOLS];
	int unsigned  scan_from;

	dspf_result_t burst_q[$];	// results caused by the item just accepted
	dspf_result_t panel_bytes_q[$];	// results still owed by the block
	dir_row_t     dir_tab [25];
	int unsigned  errors = 0;
	bit           squeeze_on = 1'b0;
	bit           tx_steady = 1'b0;

	display_dirty_page_flush #(
		.PAGES(NPAGES),
		.WIDTH(NCOLS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Model of one accepted item: updates the frame/shadow/pointer copy and
	// leaves the panel traffic it causes in burst_q.
	function automatic void predict_panel_traffic(input dspf_item_t it);
		int           pg;
		int           cnt;
		bit           differs;
		dspf_result_t r;
		burst_q.delete();
		case (it.command)
			CMD_WRITE: frame_mem[it.page][it.column] = it.value;
			CMD_OR:    frame_mem[it.page][it.column] = frame_mem[it.page][it.column] | it.value;
			CMD_CLEAR: foreach (frame_mem[p, c]) frame_mem[p][c] = '0;
			CMD_INVAL: begin
				foreach (shadow_mem[p, c]) shadow_mem[p][c] = SHADOW_FILL;
				scan_from = 0;
			end
			CMD_FLUSH: begin
				// round-robin from the scan pointer; stop at the first dirty page
				for (int a = 0; a < NPAGES; a++) begin
					if (burst_q.size() == 0) begin
						pg = (scan_from + a) % NPAGES;
						differs = 1'b0;
						for (int c = 0; c < NCOLS; c++)
							if (frame_mem[pg][c] != shadow_mem[pg][c])
								differs = 1'b1;
						if (differs) begin
							r            = '0;
							r.kind       = KIND_ADDR;
							r.payload    = {40'd0, COL_HIGH_CMD, COL_LOW_CMD,
								PAGE_ADDR_BASE | 8'(pg)};
							r.byte_count = ADDR_CMD_BYTES;
							r.sent_page  = pg[2:0];
							burst_q.push_back(r);
							for (int c = 0; c < NCOLS; c += 8) begin
								cnt          = (NCOLS - c > 8) ? 8 : NCOLS - c;
								r            = '0;
								r.kind       = KIND_DATA;
								r.byte_count = 4'(cnt);
								r.sent_page  = pg[2:0];
								r.last       = (c + cnt >= NCOLS);
								for (int b = 0; b < cnt; b++) begin
									r.payload[8*b +: 8] = frame_mem[pg][c+b];
									shadow_mem[pg][c+b] = frame_mem[pg][c+b];
								end
								burst_q.push_back(r);
							end
							scan_from = (pg + 1) % NPAGES;
						end
					end
				end
			end
			default: ;	// spare codes: no effect
		endcase
	endfunction

	// Offer one item after a random gap, hold it until the transfer, then
	// queue what it should produce.
	task automatic offer(input dir_row_t r);
		int unsigned gap;
		gap = (squeeze_on || tx_steady) ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			@(negedge clk) item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= r.stim;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_panel_traffic(r.stim);
		if (r.pinned) begin
			if (burst_q.size() == 0)
				burst_q.push_back(r.pin);
			else
				burst_q[0] = r.pin;
		end
		foreach (burst_q[k]) panel_bytes_q.push_back(burst_q[k]);
	endtask

	task automatic report_field(input string fname, input logic [63:0] want_v,
		input logic [63:0] got_v);
		$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want_v,
			got_v);
		errors++;
	endtask

	// Result side: every transfer is matched against the oldest expectation.
	always @(posedge clk) begin : check_results
		dspf_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (panel_bytes_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got %p", $time, result);
				errors++;
			end else begin
				want = panel_bytes_q.pop_front();
				if (result.kind !== want.kind)
					report_field("kind", 64'(want.kind), 64'(result.kind));
				if (result.payload !== want.payload)
					report_field("payload", want.payload, result.payload);
				if (result.byte_count !== want.byte_count)
					report_field("byte_count", 64'(want.byte_count), 64'(result.byte_count));
				if (result.sent_page !== want.sent_page)
					report_field("sent_page", 64'(want.sent_page), 64'(result.sent_page));
				if (result.last !== want.last)
					report_field("last", 64'(want.last), 64'(result.last));
			end
		end
	end

	// Result stall: random wait per transfer, with stretches of no stall and
	// one long hold-off that lets the block back up into its item input.
	initial begin : result_sink
		int unsigned hold;
		int unsigned taken;
		bit          steady;
		bit          squeezed;
		taken        = 0;
		steady       = 1'b0;
		squeezed     = 1'b0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 32 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (!squeezed && taken == SQUEEZE_AT) begin
				squeezed   = 1'b1;
				squeeze_on = 1'b1;
				hold       = SQUEEZE_CYCLES;
			end else begin
				hold = steady ? 0 : $urandom_range(0, 14);
			end
			if (hold != 0) begin
				@(negedge clk) result_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk) result_stall <= 1'b0;
			squeeze_on = 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		dir_row_t    rr;
		int unsigned live;
		int unsigned sent;
		int unsigned sel;

		item_valid = 1'b0;
		item       = '0;
		arst_n     = 1'b0;
		foreach (frame_mem[p, c]) frame_mem[p][c] = '0;
		foreach (shadow_mem[p, c]) shadow_mem[p][c] = SHADOW_FILL;
		scan_from = 0;

		// Directed steps. After reset every page differs from the 0xFF shadow.
		dir_tab[0]  = '{'{CMD_FLUSH, 3'd0, 7'd0,   8'h00}, 1'b1,
			'{KIND_ADDR, 64'h10_00B0, 4'd3, 3'd0, 1'b0}};
		dir_tab[1]  = '{'{CMD_WRITE, 3'd7, 7'd127, 8'hFF}, 1'b0, NO_PIN};
		dir_tab[2]  = '{'{CMD_WRITE, 3'd0, 7'd0,   8'h00}, 1'b0, NO_PIN};	// page 0 stays clean
		dir_tab[3]  = '{'{CMD_OR,    3'd1, 7'd64,  8'h55}, 1'b0, NO_PIN};
		dir_tab[4]  = '{'{CMD_OR,    3'd1, 7'd64,  8'hAA}, 1'b0, NO_PIN};
		dir_tab[5]  = '{'{CMD_FLUSH, 3'd0, 7'd0,   8'h00}, 1'b1,
			'{KIND_ADDR, 64'h10_00B1, 4'd3, 3'd1, 1'b0}};
		dir_tab[6]  = '{'{CMD_FLUSH, 3'd7, 7'd127, 8'hFF}, 1'b1,
			'{KIND_ADDR, 64'h10_00B2, 4'd3, 3'd2, 1'b0}};
		dir_tab[7]  = '{'{CMD_CLEAR, 3'd7, 7'd127, 8'hFF}, 1'b0, NO_PIN};
		// clear keeps the scan pointer: next flush picks up at page 3
		dir_tab[8]  = '{'{CMD_FLUSH, 3'd0, 7'd0,   8'h00}, 1'b1,
			'{KIND_ADDR, 64'h10_00B3, 4'd3, 3'd3, 1'b0}};
		dir_tab[9]  = '{'{CMD_INVAL, 3'd5, 7'd99,  8'h3C}, 1'b0, NO_PIN};
		// invalidate restarts at page 0 with every page dirty: flush all eight
		dir_tab[10] = '{'{CMD_FLUSH, 3'd0, 7'd0,   8'h00}, 1'b1,
			'{KIND_ADDR, 64'h10_00B0, 4'd3, 3'd0, 1'b0}};
		for (int i = 11; i < 17; i++)
			dir_tab[i] = '{'{CMD_FLUSH, 3'd0, 7'd0, 8'h00}, 1'b0, NO_PIN};
		dir_tab[17] = '{'{CMD_FLUSH, 3'd0, 7'd0,   8'h00}, 1'b1,
			'{KIND_ADDR, 64'h10_00B7, 4'd3, 3'd7, 1'b0}};
		// nothing dirty: no output
		dir_tab[18] = '{'{CMD_FLUSH, 3'd0, 7'd0,   8'h00}, 1'b0, NO_PIN};
		dir_tab[19] = '{'{CMD_WRITE, 3'd4, 7'd3,   8'h00}, 1'b0, NO_PIN};
		dir_tab[20] = '{'{CMD_WRITE, 3'd5, 7'd127, 8'h80}, 1'b0, NO_PIN};
		dir_tab[21] = '{'{CMD_FLUSH, 3'd0, 7'd0,   8'h00}, 1'b1,
			'{KIND_ADDR, 64'h10_00B5, 4'd3, 3'd5, 1'b0}};
		dir_tab[22] = '{'{CMD_RSVD5, 3'd0, 7'd0,   8'h00}, 1'b0, NO_PIN};
		dir_tab[23] = '{'{CMD_RSVD6, 3'd2, 7'd85,  8'hA5}, 1'b0, NO_PIN};
		dir_tab[24] = '{'{CMD_RSVD7, 3'd7, 7'd127, 8'hFF}, 1'b0, NO_PIN};

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		sent = 0;
		foreach (dir_tab[i]) begin
			if (sent % 16 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			offer(dir_tab[i]);
			sent++;
		end

		// Random traffic: mostly edits followed by flushes, so dirty pages are
		// scattered and the scan lands anywhere. A quarter of the writes put
		// back the shadow byte, which can leave a page clean again.
		live = 0;
		while (live < RAND_ITEMS) begin
			if (sent % 16 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			rr              = '0;
			rr.stim.page    = 3'($urandom_range(0, NPAGES - 1));
			rr.stim.column  = 7'($urandom_range(0, NCOLS - 1));
			rr.stim.value   = 8'($urandom_range(0, 255));
			sel             = $urandom_range(0, 99);
			if (sel < 50) begin
				rr.stim.command = CMD_WRITE;
				if ($urandom_range(0, 3) == 0)
					rr.stim.value = shadow_mem[rr.stim.page][rr.stim.column];
			end else if (sel < 68) begin
				rr.stim.command = CMD_OR;
			end else if (sel < 88) begin
				rr.stim.command = CMD_FLUSH;
			end else if (sel < 92) begin
				rr.stim.command = CMD_CLEAR;
			end else if (sel < 96) begin
				rr.stim.command = CMD_INVAL;
			end else begin
				rr.stim.command = CMD_RSVD5 + 3'($urandom_range(0, 2));
			end
			offer(rr);
			sent++;
			live++;
		end
		@(negedge clk) item_valid <= 1'b0;

		// drain, then give a trailing no-op flush time to show stray output
		while (panel_bytes_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && panel_bytes_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : watchdog
		#2_500_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
sv/dspf_pkg.sv
sv/dspf_ram.sv
sv/dspf_pack.sv
sv/display_dirty_page_flush.sv
sv/dspf_check.sv
bench/display_dirty_page_flush_tb.sv
